// ===== hdl/gcgss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcgss_pkg: shared types and constants for the generational slot sweep
// Holds the configuration bundle, the per-slot decision bundle, opcodes,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package gcgss_pkg;

	localparam int unsigned ACC_W  = 48;
	localparam int unsigned SIZE_W = 32;
	localparam int unsigned FACT_W = 4;
	localparam int unsigned OCC_W  = 34;

	localparam logic [ACC_W-1:0]  THRESHOLD_MIN_RESET   = 48'd16777216;
	localparam logic [FACT_W-1:0] THRESHOLD_FACTOR_RESET = 4'd2;
	localparam logic [OCC_W-1:0]  HEADER_BYTES           = 34'd8;
	localparam logic [OCC_W-1:0]  ALIGN_MASK             = 34'd7;
	localparam logic [ACC_W-1:0]  ACC_MAX                = {ACC_W{1'b1}};

	// register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_THRESHOLD_MIN    = 2'd0;
	localparam logic [1:0] REG_THRESHOLD_FACTOR = 2'd1;
	localparam logic [1:0] REG_STRESS_MODE      = 2'd2;

	typedef enum logic {
		OP_SWEEP     = 1'b0,
		OP_END_MAJOR = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [ACC_W-1:0]  threshold_min;
		logic [FACT_W-1:0] threshold_factor;
		logic              stress_mode;
		logic              stress_set;
	} cfg_t;

	typedef struct packed {
		logic new_old;
		logic new_marked;
		logic new_dirty;
		logic release_slot;
		logic promoted;
		logic old_freed;
		logic end_pass;
	} slot_res_t;

endpackage

// ===== hdl/gcgss_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcgss_cfg_regs: APB configuration registers
// Threshold minimum, threshold factor and stress mode, with readback.
// ----------------------------------------------------------------------------
module gcgss_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output gcgss_pkg::cfg_t   cfg
);
	import gcgss_pkg::*;

	logic [ACC_W-1:0]  threshold_min_q;
	logic [FACT_W-1:0] threshold_factor_q;
	logic              stress_mode_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_min_q    <= THRESHOLD_MIN_RESET;
			threshold_factor_q <= THRESHOLD_FACTOR_RESET;
			stress_mode_q      <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_THRESHOLD_MIN:    threshold_min_q    <= pwdata[ACC_W-1:0];
				REG_THRESHOLD_FACTOR: threshold_factor_q <= pwdata[FACT_W-1:0];
				REG_STRESS_MODE:      stress_mode_q      <= pwdata[0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_THRESHOLD_MIN:    prdata = {16'd0, threshold_min_q};
			REG_THRESHOLD_FACTOR: prdata = {60'd0, threshold_factor_q};
			REG_STRESS_MODE:      prdata = {63'd0, stress_mode_q};
			default:              prdata = 64'd0;
		endcase
	end

	always_comb begin
		cfg.threshold_min    = threshold_min_q;
		cfg.threshold_factor = threshold_factor_q;
		cfg.stress_mode      = stress_mode_q;
		// writing a one to stress mode drops the threshold to zero
		cfg.stress_set       = wr_en & (paddr[4:3] == REG_STRESS_MODE) & pwdata[0];
	end

endmodule

// ===== hdl/gcgss_slot_rule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcgss_slot_rule: per-slot sweep decision
// Applies the minor or major rule to one slot's bits, or flags end of pass.
// ----------------------------------------------------------------------------
module gcgss_slot_rule (
	input  logic                  opcode,
	input  logic                  major_mode,
	input  logic                  slot_old,
	input  logic                  slot_marked,
	input  logic                  slot_dirty,
	input  logic                  slot_is_free,
	output gcgss_pkg::slot_res_t  res
);
	import gcgss_pkg::*;

	always_comb begin
		res = '0;
		if (opcode == OP_END_MAJOR) begin
			res.end_pass = 1'b1;
		end else begin
			res.new_old    = slot_old;
			res.new_marked = slot_marked;
			res.new_dirty  = slot_dirty;
			if (!major_mode) begin
				if (!slot_old && !slot_is_free) begin
					if (slot_marked) begin
						// promote young survivor
						res.new_old    = 1'b1;
						res.new_marked = 1'b0;
						res.new_dirty  = 1'b0;
						res.promoted   = 1'b1;
					end else begin
						res.new_old      = 1'b0;
						res.new_marked   = 1'b0;
						res.new_dirty    = 1'b0;
						res.release_slot = 1'b1;
					end
				end
			end else if (!slot_is_free) begin
				if (slot_marked) begin
					res.new_marked = 1'b0;
				end else begin
					res.old_freed    = slot_old;
					res.new_old      = 1'b0;
					res.new_marked   = 1'b0;
					res.new_dirty    = 1'b0;
					res.release_slot = 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/gcgss_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcgss_accum: byte accumulators and major threshold
// Keeps old bytes, promoted occupancy since major and the threshold;
// produces the post-item old total and the major-due flag.
// ----------------------------------------------------------------------------
module gcgss_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gcgss_pkg::cfg_t             cfg,
	input  logic                        advance,
	input  gcgss_pkg::slot_res_t        res,
	input  logic [31:0]                 obj_size,
	output logic [47:0]                 old_total_nx,
	output logic                        major_due_nx
);
	import gcgss_pkg::*;

	logic [ACC_W-1:0]        old_acc_q;
	logic [ACC_W-1:0]        promoted_q;
	logic [ACC_W-1:0]        threshold_q;
	logic [ACC_W-1:0]        promoted_nx;
	logic [ACC_W-1:0]        threshold_nx;
	logic [OCC_W-1:0]        occ;
	logic [ACC_W:0]          old_sum;
	logic [ACC_W:0]          prom_sum;
	logic [ACC_W+FACT_W-1:0] product;
	logic [ACC_W-1:0]        product_sat;
	logic [ACC_W-1:0]        size_ext;

	assign size_ext = {{(ACC_W-SIZE_W){1'b0}}, obj_size};
	assign occ      = HEADER_BYTES
		+ (({2'b00, obj_size} + ALIGN_MASK) & ~ALIGN_MASK);
	assign old_sum  = {1'b0, old_acc_q} + {1'b0, size_ext};
	assign prom_sum = {1'b0, promoted_q} + {{(ACC_W+1-OCC_W){1'b0}}, occ};
	assign product  = (ACC_W+FACT_W)'(old_acc_q) * (ACC_W+FACT_W)'(cfg.threshold_factor);
	assign product_sat = (|product[ACC_W+FACT_W-1:ACC_W]) ? ACC_MAX : product[ACC_W-1:0];

	always_comb begin
		old_total_nx = old_acc_q;
		promoted_nx  = promoted_q;
		threshold_nx = threshold_q;
		if (res.end_pass) begin
			promoted_nx = '0;
			if (!cfg.stress_mode) begin
				threshold_nx = (product_sat < cfg.threshold_min) ? cfg.threshold_min
					: product_sat;
			end
		end else if (res.promoted) begin
			old_total_nx = old_sum[ACC_W] ? ACC_MAX : old_sum[ACC_W-1:0];
			promoted_nx  = prom_sum[ACC_W] ? ACC_MAX : prom_sum[ACC_W-1:0];
		end else if (res.old_freed) begin
			// saturate at zero
			old_total_nx = (old_acc_q > size_ext) ? old_acc_q - size_ext : '0;
		end
	end

	assign major_due_nx = promoted_nx > threshold_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_acc_q   <= '0;
			promoted_q  <= '0;
			threshold_q <= THRESHOLD_MIN_RESET;
		end else if (cfg.stress_set) begin
			threshold_q <= '0;
		end else if (advance) begin
			old_acc_q   <= old_total_nx;
			promoted_q  <= promoted_nx;
			threshold_q <= threshold_nx;
		end
	end

endmodule

// ===== hdl/gc_generational_slot_sweep_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc_generational_slot_sweep_top: generational heap slot sweeper
// Sweeps one slot per transaction under the minor or major rule, or closes
// a major pass, and tracks old bytes, promotion and the major threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one slot or an end-of-major
//   event per transaction; output channel (out_valid / out_stall) returns
//   exactly one result per input, in order.
//   The accepting edge loads the input register; when the result register
//   advances, it loads the result through the rule and accumulator
//   logic, raising out_valid.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the only loop is the accumulator update.
//   When the receiver stalls, the result register holds and the input
//   register keeps its item; in_stall rises only once both are full.
//   Reset clears both valid bits, zeroes the byte counters and loads the
//   threshold and configuration registers with their defaults.
//   Configuration is written over APB (64-bit data, registers at 8-byte
//   steps); the user must do so while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module gc_generational_slot_sweep_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic        major_mode,
	input  logic        slot_old,
	input  logic        slot_marked,
	input  logic        slot_dirty,
	input  logic        slot_is_free,
	input  logic [31:0] obj_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        new_old,
	output logic        new_marked,
	output logic        new_dirty,
	output logic        release_slot,
	output logic        promoted,
	output logic [47:0] old_total,
	output logic        major_due
);
	import gcgss_pkg::*;

	cfg_t        cfg;
	slot_res_t   res;
	logic        advance;
	logic        accept_in;
	logic [47:0] old_total_nx;
	logic        major_due_nx;

	logic        valid_s1;
	logic        opcode_s1;
	logic        major_mode_s1;
	logic        slot_old_s1;
	logic        slot_marked_s1;
	logic        slot_dirty_s1;
	logic        slot_is_free_s1;
	logic [31:0] obj_size_s1;

	logic        valid_s2;
	logic        new_old_s2;
	logic        new_marked_s2;
	logic        new_dirty_s2;
	logic        release_slot_s2;
	logic        promoted_s2;
	logic [47:0] old_total_s2;
	logic        major_due_s2;

	gcgss_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the input register into the result register
	assign advance   = valid_s1 & ~(valid_s2 & out_stall);
	assign in_stall  = valid_s1 & ~advance;
	assign accept_in = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			opcode_s1       <= opcode;
			major_mode_s1   <= major_mode;
			slot_old_s1     <= slot_old;
			slot_marked_s1  <= slot_marked;
			slot_dirty_s1   <= slot_dirty;
			slot_is_free_s1 <= slot_is_free;
			obj_size_s1     <= obj_size;
		end
	end

	gcgss_slot_rule u_rule (
		.opcode       (opcode_s1),
		.major_mode   (major_mode_s1),
		.slot_old     (slot_old_s1),
		.slot_marked  (slot_marked_s1),
		.slot_dirty   (slot_dirty_s1),
		.slot_is_free (slot_is_free_s1),
		.res          (res)
	);

	gcgss_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.advance      (advance),
		.res          (res),
		.obj_size     (obj_size_s1),
		.old_total_nx (old_total_nx),
		.major_due_nx (major_due_nx)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			new_old_s2      <= res.new_old;
			new_marked_s2   <= res.new_marked;
			new_dirty_s2    <= res.new_dirty;
			release_slot_s2 <= res.release_slot;
			promoted_s2     <= res.promoted;
			old_total_s2    <= old_total_nx;
			major_due_s2    <= major_due_nx;
		end
	end

	assign out_valid    = valid_s2;
	assign new_old      = new_old_s2;
	assign new_marked   = new_marked_s2;
	assign new_dirty    = new_dirty_s2;
	assign release_slot = release_slot_s2;
	assign promoted     = promoted_s2;
	assign old_total    = old_total_s2;
	assign major_due    = major_due_s2;

endmodule
